FILE: rtl/core/mbc_pkg.sv
// Shared constants, codes and types of the mirrored-border line convolution block.
package mbc_pkg;

    // Block parameters
    localparam int MAX_RADIUS    = 15;
    localparam int SAMPLE_BITS   = 16;
    localparam int TAP_FRAC_BITS = 16;

    // Port field widths
    localparam int TAP_W      = 24;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 24;
    localparam int RADIUS_W   = 4;
    localparam int TAP_IDX_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Line sample counter, saturating
    localparam int              CNT_W     = 6;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Derived sizes
    localparam int TAP_AW    = $clog2(MAX_RADIUS + 1);
    localparam int WIN_AW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int WIN_DEPTH = 1 << WIN_AW;
    localparam int PAIR_W    = SAMPLE_BITS + 1;
    localparam int PROD_W    = TAP_W + PAIR_W;
    localparam int ACC_W     = PROD_W + TAP_AW;
    localparam int OUT_MAX   = (2 ** (OUT_W - 1)) - 1;
    localparam int OUT_MIN   = -(2 ** (OUT_W - 1));
    localparam int ROUND_HALF = 1 << (TAP_FRAC_BITS - 1);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

    // Request function codes
    localparam logic FUNC_TAP    = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ODD_MODE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_EMIT,
        S_SHORT
    } ctrl_state_t;

    // One tap issued to the MAC, aligned with the window read data
    typedef struct packed {
        logic                    vld;
        logic                    first;
        logic                    last;
        logic                    odd;
        logic signed [TAP_W-1:0] tap;
    } issue_t;

    // Finished output from the MAC
    typedef struct packed {
        logic                    vld;
        logic signed [OUT_W-1:0] filtered;
        logic                    sat;
    } mac_res_t;

    // Window memory write and read ports
    typedef struct packed {
        logic                   we;
        logic [WIN_AW-1:0]      addr;
        logic [SAMPLE_BITS-1:0] data;
    } win_wr_t;

    typedef struct packed {
        logic [WIN_AW-1:0] addr_a;
        logic [WIN_AW-1:0] addr_b;
    } win_rd_t;

endpackage

FILE: rtl/core/mbc_if.sv
// Request and result channel interfaces of the line convolution block.
interface mbc_item_if;
    import mbc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [TAP_IDX_W-1:0]        tap_index;
    logic signed [TAP_W-1:0]     tap_value;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        end_of_line;

    modport source (
        output valid, func, tap_index, tap_value, sample, end_of_line,
        input  ready
    );
    modport sink (
        input  valid, func, tap_index, tap_value, sample, end_of_line,
        output ready
    );
    modport monitor (
        input valid, ready, func, tap_index, tap_value, sample, end_of_line
    );
endinterface

interface mbc_result_if;
    import mbc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  filtered;
    logic [STATUS_W-1:0]      status;
    logic                     line_done;
    logic                     last_of_run;

    modport source (
        output valid, filtered, status, line_done, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, filtered, status, line_done, last_of_run,
        output ready
    );
    modport monitor (
        input valid, ready, filtered, status, line_done, last_of_run
    );
endinterface

FILE: rtl/core/mbc_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
module mbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;
endmodule

FILE: rtl/core/mbc_mac.sv
// Shared multiply-accumulate with rounding and saturation of each output.
module mbc_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mbc_pkg::issue_t                 iss,
    input  logic [mbc_pkg::SAMPLE_BITS-1:0] rdata_a,
    input  logic [mbc_pkg::SAMPLE_BITS-1:0] rdata_b,
    output mbc_pkg::mac_res_t               res
);
    import mbc_pkg::*;

    logic signed [SAMPLE_BITS-1:0] sr;
    logic signed [SAMPLE_BITS-1:0] sl;
    logic signed [PAIR_W-1:0]      pair;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          prod_vld_reg;
    logic                          prod_first_reg;
    logic                          prod_last_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       acc_reg;
    logic                          acc_done_reg;
    logic signed [ACC_W:0]         rnd;
    logic signed [ACC_W:0]         shifted;
    logic                          res_vld_reg;
    logic signed [OUT_W-1:0]       res_filtered_reg;
    logic                          res_sat_reg;
    logic signed [OUT_W-1:0]       filtered_next;
    logic                          sat_next;

    // Pair forming and product: the centre tap takes the sample alone
    assign sr = rdata_a;
    assign sl = rdata_b;

    always_comb
    begin
        if (iss.first)
        begin
            pair = PAIR_W'(sr);
        end
        else if (iss.odd)
        begin
            pair = PAIR_W'(sr) - PAIR_W'(sl);
        end
        else
        begin
            pair = PAIR_W'(sr) + PAIR_W'(sl);
        end
        prod_next = PROD_W'(iss.tap) * PROD_W'(pair);
    end

    // Accumulate
    assign acc_next = prod_first_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    // Round half up, drop the fraction, saturate
    always_comb
    begin
        rnd     = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(ROUND_HALF);
        shifted = rnd >>> TAP_FRAC_BITS;
        if (shifted > (ACC_W + 1)'(OUT_MAX))
        begin
            filtered_next = OUT_W'(OUT_MAX);
            sat_next      = 1'b1;
        end
        else if (shifted < (ACC_W + 1)'(OUT_MIN))
        begin
            filtered_next = OUT_W'(OUT_MIN);
            sat_next      = 1'b1;
        end
        else
        begin
            filtered_next = shifted[OUT_W-1:0];
            sat_next      = 1'b0;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_done_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= iss.vld;
            acc_done_reg <= prod_vld_reg && prod_last_reg;
            res_vld_reg  <= acc_done_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        prod_first_reg <= iss.first;
        prod_last_reg  <= iss.last;
        if (prod_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        if (acc_done_reg)
        begin
            res_filtered_reg <= filtered_next;
            res_sat_reg      <= sat_next;
        end
    end

    assign res.vld      = res_vld_reg;
    assign res.filtered = res_filtered_reg;
    assign res.sat      = res_sat_reg;
endmodule

FILE: rtl/core/mbc_ctrl.sv
// Sequencer: configuration, tap store, window addressing and result register.
module mbc_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbc_pkg::CFG_DATA_W-1:0] cfg_data,
    mbc_item_if.sink                       item,
    mbc_result_if.source                   result,
    output mbc_pkg::win_wr_t               win_wr,
    output mbc_pkg::win_rd_t               win_rd,
    output mbc_pkg::issue_t                iss,
    input  mbc_pkg::mac_res_t              mac_res
);
    import mbc_pkg::*;

    ctrl_state_t state_reg, state_next;

    logic [RADIUS_W-1:0]     radius_reg;
    logic                    odd_reg;
    logic signed [TAP_W-1:0] taps_reg [MAX_RADIUS + 1];

    logic [CNT_W-1:0]  line_cnt_reg, line_cnt_next;
    logic [CNT_W-1:0]  run_cnt_reg, run_cnt_next;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic [TAP_AW-1:0] d_reg, d_next;
    logic [TAP_AW-1:0] i_reg, i_next;
    logic              eol_reg, eol_next;
    issue_t            iss_reg, iss_next;

    logic                    out_vld_reg, out_vld_next;
    logic signed [OUT_W-1:0] out_filtered_reg, out_filtered_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic                    out_line_done_reg, out_line_done_next;
    logic                    out_last_reg, out_last_next;
    logic                    load_out;
    logic                    out_free;

    logic [TAP_AW-1:0] r_eff;
    logic [CNT_W-1:0]  cnt_inc;
    logic              accept;
    logic [TAP_AW-1:0] ra;
    logic [CNT_W-1:0]  pos_sum;
    logic [CNT_W-1:0]  cm1;
    logic [CNT_W:0]    la;

    assign r_eff    = (int'(radius_reg) > MAX_RADIUS) ? TAP_AW'(MAX_RADIUS)
                                                      : TAP_AW'(radius_reg);
    assign cnt_inc  = (line_cnt_reg < COUNT_MAX) ? line_cnt_reg + 1'b1 : line_cnt_reg;
    assign accept   = item.valid && item.ready;
    assign out_free = !out_vld_reg || result.ready;

    // Window addresses of the right and left partners of tap i around centre d.
    // Both borders reflect without repeating the edge sample.
    always_comb
    begin
        ra      = (d_reg >= i_reg) ? d_reg - i_reg : i_reg - d_reg;
        pos_sum = CNT_W'(d_reg) + CNT_W'(i_reg);
        cm1     = run_cnt_reg - 1'b1;
        if (pos_sum <= cm1)
        begin
            la = {1'b0, pos_sum};
        end
        else
        begin
            la = {cm1, 1'b0} - {1'b0, pos_sum};
        end
        win_rd.addr_a = wp_reg - WIN_AW'(ra);
        win_rd.addr_b = wp_reg - la[WIN_AW-1:0];
    end

    // Samples are written only in IDLE, reads happen only in RUN: no overlap
    assign win_wr.we   = accept && (item.func == FUNC_SAMPLE);
    assign win_wr.addr = wp_reg + 1'b1;
    assign win_wr.data = SAMPLE_BITS'(item.sample);

    // Next state and outputs
    always_comb
    begin
        state_next         = state_reg;
        line_cnt_next      = line_cnt_reg;
        run_cnt_next       = run_cnt_reg;
        wp_next            = wp_reg;
        d_next             = d_reg;
        i_next             = i_reg;
        eol_next           = eol_reg;
        iss_next           = '0;
        load_out           = 1'b0;
        out_filtered_next  = out_filtered_reg;
        out_status_next    = out_status_reg;
        out_line_done_next = out_line_done_reg;
        out_last_next      = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid && item.func == FUNC_SAMPLE)
                begin
                    wp_next      = wp_reg + 1'b1;
                    run_cnt_next = cnt_inc;
                    d_next       = r_eff;
                    i_next       = '0;
                    eol_next     = item.end_of_line;
                    if (item.end_of_line)
                    begin
                        line_cnt_next = '0;
                        state_next    = (cnt_inc > CNT_W'(r_eff)) ? S_RUN : S_SHORT;
                    end
                    else
                    begin
                        line_cnt_next = cnt_inc;
                        if (cnt_inc > CNT_W'(r_eff))
                        begin
                            state_next = S_RUN;
                        end
                    end
                end
            end
            S_RUN:
            begin
                iss_next.vld   = 1'b1;
                iss_next.first = (i_reg == '0);
                iss_next.last  = (i_reg == r_eff);
                iss_next.odd   = odd_reg;
                iss_next.tap   = taps_reg[i_reg];
                if (i_reg == r_eff)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                if (mac_res.vld)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out           = 1'b1;
                    out_filtered_next  = mac_res.filtered;
                    out_status_next    = mac_res.sat ? ST_SAT : ST_OK;
                    out_line_done_next = eol_reg && (d_reg == '0);
                    out_last_next      = !eol_reg || (d_reg == '0);
                    if (!eol_reg || d_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg - 1'b1;
                        i_next     = '0;
                        state_next = S_RUN;
                    end
                end
            end
            S_SHORT:
            begin
                if (out_free)
                begin
                    load_out           = 1'b1;
                    out_filtered_next  = '0;
                    out_status_next    = ST_SHORT;
                    out_line_done_next = 1'b1;
                    out_last_next      = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_vld_next = load_out || (out_vld_reg && !result.ready);
    end

    // Control registers, configuration and tap store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            radius_reg   <= RADIUS_RESET;
            odd_reg      <= 1'b0;
            line_cnt_reg <= '0;
            run_cnt_reg  <= '0;
            wp_reg       <= '0;
            d_reg        <= '0;
            i_reg        <= '0;
            eol_reg      <= 1'b0;
            iss_reg      <= '0;
            out_vld_reg  <= 1'b0;
            for (int k = 0; k <= MAX_RADIUS; k++)
            begin
                taps_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            line_cnt_reg <= line_cnt_next;
            run_cnt_reg  <= run_cnt_next;
            wp_reg       <= wp_next;
            d_reg        <= d_next;
            i_reg        <= i_next;
            eol_reg      <= eol_next;
            iss_reg      <= iss_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RADIUS:   radius_reg <= cfg_data;
                    REG_ODD_MODE: odd_reg    <= cfg_data[0];
                    default:      radius_reg <= radius_reg;
                endcase
            end
            // Tap writes past the store are dropped
            if (accept && item.func == FUNC_TAP && int'(item.tap_index) <= MAX_RADIUS)
            begin
                taps_reg[TAP_AW'(item.tap_index)] <= item.tap_value;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_filtered_reg  <= out_filtered_next;
            out_status_reg    <= out_status_next;
            out_line_done_reg <= out_line_done_next;
            out_last_reg      <= out_last_next;
        end
    end

    assign item.ready         = (state_reg == S_IDLE);
    assign iss                = iss_reg;
    assign result.valid       = out_vld_reg;
    assign result.filtered    = out_filtered_reg;
    assign result.status      = out_status_reg;
    assign result.line_done   = out_line_done_reg;
    assign result.last_of_run = out_last_reg;
endmodule

FILE: rtl/core/mirrored_border_line_convolution_top.sv
// A sample that completes an output sends each tap through the issue register, window
// read, product register and accumulator, then the rounded and sequencer result registers;
// an end-of-line flush repeats this per further output. A tap write or a sample completing
// nothing leaves the block ready; other samples hold off new requests until their last
// result is loaded. Reset: taps clear to zero, radius to 1, odd_mode to 0, line count to
// zero; the window memory is not cleared and needs no clearing pass.
module mirrored_border_line_convolution_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbc_pkg::CFG_DATA_W-1:0] cfg_data,
    mbc_item_if.sink                       item,
    mbc_result_if.source                   result
);
    import mbc_pkg::*;

    win_wr_t                win_wr;
    win_rd_t                win_rd;
    issue_t                 iss;
    mac_res_t               mac_res;
    logic [SAMPLE_BITS-1:0] rdata_a;
    logic [SAMPLE_BITS-1:0] rdata_b;

    // Sequencer
    mbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .result    (result),
        .win_wr    (win_wr),
        .win_rd    (win_rd),
        .iss       (iss),
        .mac_res   (mac_res)
    );

    // Sample window ring buffer
    mbc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .clk     (clk),
        .we      (win_wr.we),
        .waddr   (win_wr.addr),
        .wdata   (win_wr.data),
        .raddr_a (win_rd.addr_a),
        .rdata_a (rdata_a),
        .raddr_b (win_rd.addr_b),
        .rdata_b (rdata_b)
    );

    // Multiply-accumulate
    mbc_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .iss     (iss),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .res     (mac_res)
    );
endmodule

FILE: rtl/core/mbc_checker.sv
// Port-level assertions for the line convolution block, bound to the top level.
module mbc_checker (
    input logic          clk,
    input logic          rst_n,
    mbc_item_if.sink     item,
    mbc_result_if.source result
);
    import mbc_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.filtered)
            && $stable(result.status) && $stable(result.last_of_run))
        else $error("stalled result changed");

    // Short-line result shape
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_SHORT |->
            result.filtered == '0 && result.line_done && result.last_of_run)
        else $error("malformed short-line result");

    // Final result of a line closes its run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.line_done |-> result.last_of_run)
        else $error("line_done without last_of_run");

    // Saturated results sit at a rail
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_SAT |->
            result.filtered == 24'sh7fffff || result.filtered == 24'sh800000)
        else $error("saturated result off the rail");

    // A tap write keeps the block ready for the next request
    a_tap: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready && item.func == FUNC_TAP |=> item.ready)
        else $error("tap write blocked the request channel");
endmodule

bind mirrored_border_line_convolution_top mbc_checker u_mbc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .result (result)
);

FILE: bench/tb_mirrored_border_line_convolution_top.sv
// Self-checking bench for the mirrored-border line convolution block, with a built-in predictor.
module tb_mirrored_border_line_convolution_top;
    import mbc_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PCT       = 36;
    localparam int RANDOM_ITEMS   = 280;
    localparam int SETTLE_CYCLES  = 2 * (MAX_RADIUS + 7);
    localparam int DRAIN_LIMIT    = 100000;
    localparam int HOLD_OFF       = 300;
    localparam int MAX_REPORTS    = 100;
    localparam longint TIMEOUT_CYCLES = 1000000;

    typedef struct {
        logic signed [OUT_W-1:0] filtered;
        logic [STATUS_W-1:0]     status;
        logic                    line_done;
        logic                    last_of_run;
    } conv_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    mbc_item_if   item_ch ();
    mbc_result_if result_ch ();

    mirrored_border_line_convolution_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // Predictor state: line window (newest first), taps, line length, registers
    logic signed [SAMPLE_W-1:0] line_win [WIN_DEPTH];
    logic signed [TAP_W-1:0]    tap_store [MAX_RADIUS+1];
    logic [CNT_W-1:0]           line_len;
    logic [RADIUS_W-1:0]        cur_radius;
    logic                       cur_odd;

    conv_result_t pending_outputs [$];

    int  errors          = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  lines_sent      = 0;
    int  settings_used   = 0;
    int  random_start    = 0;
    int  hold_request    = 0;
    int  hold_left       = 0;
    bit  no_idle         = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout after %0d cycles, %0d results still pending",
                 TIMEOUT_CYCLES, pending_outputs.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // One output whose centre sits d samples behind the newest, cnt samples in the line
    function automatic conv_result_t convolve_at(input int d, input int r, input int cnt);
        conv_result_t res;
        longint acc;
        longint sr;
        longint sl;
        longint v;
        int x;
        int ra;
        int la;
        int i;
        x = cnt - 1 - d;
        acc = longint'(tap_store[0]) * longint'(line_win[d]);
        for (i = 1; i <= r; i++)
        begin
            // reflect past either border without repeating the edge sample
            ra = (d >= i) ? d - i : i - d;
            la = (x >= i) ? d + i : (cnt - 1) - (i - x);
            sr = line_win[ra % WIN_DEPTH];
            sl = line_win[la % WIN_DEPTH];
            acc += longint'(tap_store[i]) * (cur_odd ? sr - sl : sr + sl);
        end
        v = (acc + ROUND_HALF) >>> TAP_FRAC_BITS;
        res.status = ST_OK;
        if (v > OUT_MAX)
        begin
            v = OUT_MAX;
            res.status = ST_SAT;
        end
        if (v < OUT_MIN)
        begin
            v = OUT_MIN;
            res.status = ST_SAT;
        end
        res.filtered    = v[OUT_W-1:0];
        res.line_done   = 1'b0;
        res.last_of_run = 1'b0;
        return res;
    endfunction

    // Advance the predictor by one accepted request and queue what it yields
    task automatic forecast_outputs(input logic func, input logic [TAP_IDX_W-1:0] idx,
                                    input logic signed [TAP_W-1:0] tapv,
                                    input logic signed [SAMPLE_W-1:0] samp, input logic eol);
        conv_result_t res;
        int r;
        int cnt;
        int d;
        int k;
        if (func == FUNC_TAP)
        begin
            if (idx <= MAX_RADIUS)
                tap_store[idx] = tapv;
        end
        else
        begin
            r = (cur_radius > MAX_RADIUS) ? MAX_RADIUS : cur_radius;
            for (k = WIN_DEPTH - 1; k > 0; k--)
                line_win[k] = line_win[k-1];
            line_win[0] = samp;
            if (line_len < COUNT_MAX)
                line_len++;
            cnt = line_len;
            if (!eol)
            begin
                if (cnt >= r + 1)
                begin
                    res = convolve_at(r, r, cnt);
                    res.last_of_run = 1'b1;
                    pending_outputs.push_back(res);
                end
            end
            else
            begin
                line_len = '0;
                if (cnt < r + 1)
                begin
                    res.filtered    = '0;
                    res.status      = ST_SHORT;
                    res.line_done   = 1'b1;
                    res.last_of_run = 1'b1;
                    pending_outputs.push_back(res);
                end
                else
                begin
                    // flush every output still waiting, oldest centre first
                    for (d = r; d >= 0; d--)
                    begin
                        res = convolve_at(d, r, cnt);
                        res.line_done   = (d == 0);
                        res.last_of_run = (d == 0);
                        pending_outputs.push_back(res);
                    end
                end
            end
        end
    endtask

    // Result side: random ready with optional long hold-off, and checking
    always @(posedge clk)
    begin : result_check
        conv_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_outputs.size() == 0)
                report_mismatch($sformatf("unexpected result filtered=%0d status=%0d",
                                          result_ch.filtered, result_ch.status));
            else
            begin
                want = pending_outputs.pop_front();
                results_checked++;
                if (result_ch.filtered !== want.filtered)
                    report_mismatch($sformatf("filtered got %0d want %0d",
                                              result_ch.filtered, want.filtered));
                if (result_ch.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result_ch.status, want.status));
                if (result_ch.line_done !== want.line_done)
                    report_mismatch($sformatf("line_done got %0b want %0b",
                                              result_ch.line_done, want.line_done));
                if (result_ch.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run got %0b want %0b",
                                              result_ch.last_of_run, want.last_of_run));
            end
        end
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Send one request; valid stays high afterwards until the next gap or drain
    task automatic send_request(input logic func, input logic [TAP_IDX_W-1:0] idx,
                                input logic signed [TAP_W-1:0] tapv,
                                input logic signed [SAMPLE_W-1:0] samp, input logic eol);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_ch.valid       <= 1'b1;
        item_ch.func        <= func;
        item_ch.tap_index   <= idx;
        item_ch.tap_value   <= tapv;
        item_ch.sample      <= samp;
        item_ch.end_of_line <= eol;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
        forecast_outputs(func, idx, tapv, samp, eol);
    endtask

    task automatic send_tap(input int idx, input logic signed [TAP_W-1:0] value);
        send_request(FUNC_TAP, TAP_IDX_W'(idx), value, SAMPLE_W'($urandom),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] samp, input logic eol);
        send_request(FUNC_SAMPLE, TAP_IDX_W'($urandom), TAP_W'($urandom), samp, eol);
    endtask

    function automatic logic signed [TAP_W-1:0] rand_tap();
        int v;
        case ($urandom_range(0, 9))
            0: return {1'b0, {(TAP_W-1){1'b1}}};
            1: return {1'b1, {(TAP_W-1){1'b0}}};
            2: return TAP_W'($urandom);
            default:
            begin
                // mostly within +-1.0 so that few outputs clip
                v = int'($urandom_range(0, 131071)) - 65536;
                return v[TAP_W-1:0];
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // One line of random samples; a noisy line slips tap writes in between
    task automatic send_line(input int len, input bit noisy);
        int k;
        for (k = 0; k < len; k++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_tap($urandom_range(0, MAX_RADIUS), rand_tap());
            send_sample(rand_sample(), k == len - 1);
        end
        lines_sent++;
    endtask

    // Wait for all pending results, then let the block finish any silent work
    task automatic drain_outputs();
        int waited;
        waited = 0;
        item_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers; only called right after drain_outputs
    task automatic write_config(input logic [CFG_DATA_W-1:0] radius_data,
                                input logic [CFG_DATA_W-1:0] odd_data);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RADIUS;
        cfg_data  <= radius_data;
        @(posedge clk);
        cur_radius = radius_data[RADIUS_W-1:0];
        cfg_index <= REG_ODD_MODE;
        cfg_data  <= odd_data;
        @(posedge clk);
        cur_odd = odd_data[0];
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Reset defaults, extreme taps and samples, clipping both ways
    task automatic test_taps_and_extremes();
        send_tap(0, {1'b0, {(TAP_W-1){1'b1}}});
        send_tap(1, {1'b1, {(TAP_W-1){1'b0}}});
        send_tap(MAX_RADIUS, rand_tap());
        send_sample(16'sh7fff, 1'b0);
        send_sample(-16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(-16'sh8000, 1'b1);
        lines_sent++;
        drain_outputs();
    endtask

    // Lines shorter than radius+1, including a single-sample line
    task automatic test_short_lines();
        write_config(4'd3, 4'd0);
        send_tap(2, 24'sh008000);
        send_line(1, 1'b0);
        send_line(3, 1'b0);
        drain_outputs();
    endtask

    // Zero radius: centre tap only, one output per sample
    task automatic test_zero_radius();
        write_config(4'd0, 4'd1);
        send_tap(0, 24'sh010000);
        send_line(2, 1'b0);
        drain_outputs();
    endtask

    // Antisymmetric mode across both borders
    task automatic test_odd_mode();
        write_config(4'd2, 4'd1);
        send_tap(1, rand_tap());
        send_tap(2, rand_tap());
        send_line(4, 1'b0);
        drain_outputs();
    endtask

    // Radius, mode and a tap change in the middle of a line
    task automatic test_mid_line_change();
        write_config(4'd1, 4'd0);
        send_sample(rand_sample(), 1'b0);
        send_sample(rand_sample(), 1'b0);
        send_sample(rand_sample(), 1'b0);
        drain_outputs();
        write_config(4'd3, 4'd1);
        send_tap(3, rand_tap());
        send_sample(rand_sample(), 1'b0);
        send_sample(rand_sample(), 1'b0);
        send_sample(rand_sample(), 1'b1);
        lines_sent++;
        drain_outputs();
    endtask

    // Receiver holds off while requests keep coming, then the sender waits it out
    task automatic test_backpressure();
        write_config(4'd1, 4'd0);
        hold_request = HOLD_OFF;
        send_line(24, 1'b0);
        drain_outputs();
    endtask

    // Full radius, every tap written, no idling on either side
    task automatic test_burst_no_idle();
        int k;
        no_idle = 1'b1;
        write_config(4'(MAX_RADIUS), 4'($urandom_range(0, 15)));
        for (k = 0; k <= MAX_RADIUS; k++)
            send_tap(k, rand_tap());
        send_line(MAX_RADIUS + 5, 1'b0);
        drain_outputs();
        no_idle = 1'b0;
    endtask

    // Line longer than the saturating sample counter
    task automatic test_long_line();
        write_config(4'($urandom_range(1, 3)), 4'($urandom_range(0, 15)));
        send_line(int'(COUNT_MAX) + 3, 1'b0);
        drain_outputs();
    endtask

    // Random settings, taps and lines until the request budget is spent
    task automatic test_random_lines();
        int r;
        int k;
        int len;
        int nlines;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       r = 0;
                1:       r = MAX_RADIUS;
                2, 3:    r = 1;
                default: r = $urandom_range(2, 6);
            endcase
            write_config(4'(r), 4'($urandom_range(0, 15)));
            for (k = $urandom_range(0, 4); k > 0; k--)
                send_tap($urandom_range(0, r), rand_tap());
            for (nlines = $urandom_range(1, 3); nlines > 0; nlines--)
            begin
                if ($urandom_range(0, 9) < 2)
                    len = $urandom_range(1, r + 1);
                else
                    len = $urandom_range(r + 1, r + 6);
                send_line(len, $urandom_range(0, 3) == 0);
            end
            drain_outputs();
        end
    endtask

    // Main sequence
    initial
    begin
        line_len   = '0;
        cur_radius = RADIUS_RESET;
        cur_odd    = 1'b0;
        for (int k = 0; k <= MAX_RADIUS; k++)
            tap_store[k] = '0;
        for (int k = 0; k < WIN_DEPTH; k++)
            line_win[k] = '0;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_RADIUS;
        cfg_data            <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.func        <= FUNC_TAP;
        item_ch.tap_index   <= '0;
        item_ch.tap_value   <= '0;
        item_ch.sample      <= '0;
        item_ch.end_of_line <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        random_start = items_sent;
        test_taps_and_extremes();
        test_short_lines();
        test_zero_radius();
        test_odd_mode();
        test_mid_line_change();

        test_backpressure();
        test_burst_no_idle();
        test_long_line();
        test_random_lines();

        drain_outputs();
        if (pending_outputs.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_outputs.size()));

        $display("Covered %0d requests in %0d lines over %0d register settings",
                 items_sent, lines_sent, settings_used);
        $display("Checked %0d results, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
